// ===== design/eds_pkg.sv =====
// ============================================================================
// eds_pkg: shared constants for the Euclidean distance block
// Default coordinate width and the fixed width of the distance result.
// ============================================================================
`default_nettype none

package eds_pkg;

    // Default coordinate width in bits, signed Q8.8 at sixteen bits.
    localparam int COORD_WIDTH_DEF = 16;

    // Width of the distance result, unsigned Q9.8.
    localparam int SPAN_WIDTH = 17;

endpackage : eds_pkg

`default_nettype wire

// ===== design/euclidean_distance_sqrt.sv =====
// Path: an accepted word passes through three front stages, one root cell per
// root bit (one cell per digit) and the output register on its way to the
// result word.
// Throughput: one word per cycle while the skid slot is empty.
// Reset: synchronous, active low; clears every valid bit and the output slot.
// ============================================================================
// euclidean_distance_sqrt: distance between two fixed-point points
// Computes floor(sqrt(dx*dx + dy*dy)) with a pipelined chain of root cells,
// followed by an output register with a one-word skid slot.
// ============================================================================
`default_nettype none

module euclidean_distance_sqrt #(
    parameter int COORD_WIDTH = eds_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic signed [COORD_WIDTH-1:0]        i_first_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_first_y,
    input  wire logic signed [COORD_WIDTH-1:0]        i_second_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_second_y,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [eds_pkg::SPAN_WIDTH-1:0]            o_span_length
);

    localparam int RW = COORD_WIDTH + 1;
    localparam int SW = 2 * RW;
    localparam int OW = eds_pkg::SPAN_WIDTH;

    logic          adv;
    logic          out_take;
    logic          front_valid;
    logic [SW-1:0] front_sum;

    logic          c_valid [0:RW];
    logic [RW:0]   c_rem   [0:RW];
    logic [RW-1:0] c_root  [0:RW];
    logic [SW-1:0] c_rad   [0:RW];

    logic [OW-1:0] new_span;

    logic          r_out_valid;
    logic          r_skid_valid;
    logic [OW-1:0] r_out;
    logic [OW-1:0] r_skid;
    logic          n_out_valid;
    logic          n_skid_valid;
    logic [OW-1:0] n_out;
    logic [OW-1:0] n_skid;

    // The whole pipeline moves unless the skid slot holds a word.
    assign adv      = !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = r_skid_valid;

    // Difference, square and sum stages.
    eds_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_valid    (i_valid),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .o_valid    (front_valid),
        .o_sum      (front_sum)
    );

    // The first cell starts from an empty root and remainder.
    assign c_valid[0] = front_valid;
    assign c_rem[0]   = '0;
    assign c_root[0]  = '0;
    assign c_rad[0]   = front_sum;

    // One cell per root bit, most significant first.
    for (genvar g = 0; g < RW; g++) begin : g_cell
        eds_root_cell #(
            .RW (RW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (c_valid[g]),
            .i_rem   (c_rem[g]),
            .i_root  (c_root[g]),
            .i_rad   (c_rad[g]),
            .o_valid (c_valid[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_root  (c_root[g+1]),
            .o_rad   (c_rad[g+1])
        );
    end

    // The result keeps the low bits of the root, zero-extended when narrower.
    if (RW >= OW) begin : g_span_trim
        assign new_span = c_root[RW][OW-1:0];
    end else begin : g_span_ext
        assign new_span = {{(OW-RW){1'b0}}, c_root[RW]};
    end

    // Output register and skid slot: a word leaving the array goes to the
    // output when it is free or being taken, otherwise to the skid slot.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (c_valid[RW]) begin
            if (!r_out_valid || out_take) begin
                n_out       = new_span;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = new_span;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    // Output control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid       = r_out_valid;
    assign o_span_length = r_out;

    // The skid slot only ever fills behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a word while the output is empty");

    // The skid slot fills only when a finished word meets a stalled output.
    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(c_valid[RW] && r_out_valid && i_stall))
        else $error("skid slot filled without a stalled output");

    // While the skid slot is full the array holds its last word.
    a_array_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && c_valid[RW]) |=> (c_valid[RW] && $stable(c_root[RW])))
        else $error("root array moved while the skid slot was full");

    // A taken output with a full skid slot is refilled from that slot.
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid
                                        && r_out == $past(r_skid)))
        else $error("skid slot did not drain into the output register");

endmodule : euclidean_distance_sqrt

`default_nettype wire

// ===== design/eds_front.sv =====
// ============================================================================
// eds_front: difference, square and sum stages
// Forms the coordinate differences, their magnitudes, their exact squares and
// the exact sum of squares over three registered stages.
// ============================================================================
`default_nettype none

module eds_front #(
    parameter int COORD_WIDTH = eds_pkg::COORD_WIDTH_DEF,
    localparam int DW = COORD_WIDTH + 1,
    localparam int SW = 2 * DW
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic                          i_valid,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_second_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_second_y,
    output logic                               o_valid,
    output logic [SW-1:0]                      o_sum
);

    logic [2:0]    r_valid;
    logic [DW-1:0] r_mag_x;
    logic [DW-1:0] r_mag_y;
    logic [SW-1:0] r_sq_x;
    logic [SW-1:0] r_sq_y;
    logic [SW-1:0] r_sum;

    logic [DW-1:0] n_dx;
    logic [DW-1:0] n_dy;
    logic [DW-1:0] n_mag_x;
    logic [DW-1:0] n_mag_y;
    logic [SW-1:0] n_sq_x;
    logic [SW-1:0] n_sq_y;
    logic [SW-1:0] n_sum;

    // Differences are exact with one extra bit; the magnitude of the most
    // negative difference still fits as an unsigned value.
    always_comb begin
        n_dx    = {i_second_x[COORD_WIDTH-1], i_second_x}
                - {i_first_x[COORD_WIDTH-1], i_first_x};
        n_dy    = {i_second_y[COORD_WIDTH-1], i_second_y}
                - {i_first_y[COORD_WIDTH-1], i_first_y};
        n_mag_x = n_dx[DW-1] ? (~n_dx + DW'(1)) : n_dx;
        n_mag_y = n_dy[DW-1] ? (~n_dy + DW'(1)) : n_dy;
    end

    // One multiplier per axis, each followed by its own register.
    assign n_sq_x = SW'(r_mag_x) * SW'(r_mag_x);
    assign n_sq_y = SW'(r_mag_y) * SW'(r_mag_y);

    // The sum of the two squares cannot overflow the doubled width.
    assign n_sum = r_sq_x + r_sq_y;

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 3'b000;
        end else if (i_adv) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mag_x <= n_mag_x;
            r_mag_y <= n_mag_y;
            r_sq_x  <= n_sq_x;
            r_sq_y  <= n_sq_y;
            r_sum   <= n_sum;
        end
    end

    assign o_valid = r_valid[2];
    assign o_sum   = r_sum;

endmodule : eds_front

`default_nettype wire

// ===== design/eds_root_cell.sv =====
// ============================================================================
// eds_root_cell: one digit of the square root array
// Brings down the next pair of radicand bits, tries the next root bit and
// hands the partial remainder, partial root and radicand to the next cell.
// ============================================================================
`default_nettype none

module eds_root_cell #(
    parameter int RW = eds_pkg::COORD_WIDTH_DEF + 1,
    localparam int SW = 2 * RW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  wire logic [RW:0]   i_rem,
    input  wire logic [RW-1:0] i_root,
    input  wire logic [SW-1:0] i_rad,
    output logic               o_valid,
    output logic [RW:0]        o_rem,
    output logic [RW-1:0]      o_root,
    output logic [SW-1:0]      o_rad
);

    logic          r_valid;
    logic [RW:0]   r_rem;
    logic [RW-1:0] r_root;
    logic [SW-1:0] r_rad;

    logic [RW+2:0] n_shifted;
    logic [RW+2:0] n_trial;
    logic          n_fits;
    logic [RW+2:0] n_diff;
    logic [RW:0]   n_rem;
    logic [RW-1:0] n_root;

    // Restoring root step: subtract 4*root+1 when the remainder allows it.
    // The remainder never exceeds twice the root, so it fits in RW+1 bits.
    always_comb begin
        n_shifted = {i_rem, i_rad[SW-1 -: 2]};
        n_trial   = {1'b0, i_root, 2'b01};
        n_fits    = (n_shifted >= n_trial);
        n_diff    = n_shifted - n_trial;
        n_rem     = n_fits ? n_diff[RW:0] : n_shifted[RW:0];
        n_root    = {i_root[RW-2:0], n_fits};
    end

    // Valid bit of this cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Partial results handed on to the next cell.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= {i_rad[SW-3:0], 2'b00};
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;

endmodule : eds_root_cell

`default_nettype wire

// ===== sim/euclidean_distance_sqrt_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// euclidean_distance_sqrt_test: self-checking bench for the distance block
// Drives point pairs through the valid/stall input channel and compares each
// output word with the distance predicted here: floor(sqrt(dx*dx + dy*dy)) in
// Q9.8 units. Both channels idle and stall at random; the receiver also holds
// off for a long stretch so that the pipeline fills and stalls its input.
// ============================================================================

module euclidean_distance_sqrt_test;

    typedef logic signed [eds_pkg::COORD_WIDTH_DEF-1:0] t_coord;
    typedef logic [eds_pkg::SPAN_WIDTH-1:0]             t_span;

    localparam int DRAIN_CYCLES   = eds_pkg::COORD_WIDTH_DEF + 15;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_stall;
    t_coord i_first_x = '0;
    t_coord i_first_y = '0;
    t_coord i_second_x = '0;
    t_coord i_second_y = '0;
    logic   o_valid;
    logic   i_stall = 1'b0;
    t_span  o_span_length;

    // Distances still owed by the block, oldest first.
    t_span span_expected[$];
    int    error_count = 0;
    int    idle_cycles = 0;
    int    stall_hold_cycles = 0;
    bit    quiet_stretch = 1'b0;

    euclidean_distance_sqrt dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_first_x     (i_first_x),
        .i_first_y     (i_first_y),
        .i_second_x    (i_second_x),
        .i_second_y    (i_second_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_span_length (o_span_length)
    );

    always #5 i_clk = ~i_clk;

    // Exact squared distance, then a digit-by-digit integer root.
    function automatic t_span predict_span(t_coord fx, t_coord fy, t_coord sx, t_coord sy);
        longint          dx;
        longint          dy;
        longint unsigned sum_sq;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned trial;
        dx     = longint'(sx) - longint'(fx);
        dy     = longint'(sy) - longint'(fy);
        sum_sq = longint'(dx * dx + dy * dy);
        rem    = 0;
        root   = 0;
        for (int k = 31; k >= 0; k--) begin
            rem   = (rem << 2) | ((sum_sq >> (2 * k)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return t_span'(root);
    endfunction

    // Offers one point pair, with a random gap first, and holds it until taken.
    task automatic send_points(t_coord fx, t_coord fy, t_coord sx, t_coord sy);
        @(negedge i_clk);
        while (!quiet_stretch && $urandom_range(99) < 20) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_first_x  = fx;
        i_first_y  = fy;
        i_second_x = sx;
        i_second_y = sy;
        do @(posedge i_clk); while (o_stall);
        span_expected.push_back(predict_span(fx, fy, sx, sy));
    endtask

    // Lowers valid and waits until every owed distance has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (span_expected.size() != 0) @(posedge i_clk);
    endtask

    // Points that coincide give a zero distance.
    task automatic test_coincident_points();
        send_points(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_points(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
        send_points(16'sh1234, -16'sh0567, 16'sh1234, -16'sh0567);
    endtask

    // Extremes of the coordinate range along each axis and both diagonals.
    task automatic test_extreme_coordinates();
        send_points(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_points(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
        send_points(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_points(16'sh8000, 16'sd0, 16'sh7FFF, 16'sd0);
        send_points(16'sd0, 16'sh7FFF, 16'sd0, 16'sh8000);
        send_points(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_points(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
        send_points(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555);
        send_points(-16'sd1, -16'sd1, 16'sd0, 16'sd0);
        send_points(16'sh7FFF, 16'sd0, 16'sh8000, 16'sd0);
    endtask

    // Small steps and exact roots, where truncation is easy to see.
    task automatic test_small_and_exact();
        send_points(16'sd0, 16'sd0, 16'sd1, 16'sd0);
        send_points(16'sd0, 16'sd0, 16'sd1, 16'sd1);
        send_points(16'sd0, 16'sd0, 16'sd0, -16'sd2);
        send_points(16'sd0, 16'sd0, 16'sd768, 16'sd1024);
        send_points(16'sd256, -16'sd256, -16'sd1280, 16'sd2816);
        send_points(16'sd0, 16'sd0, 16'sd3, 16'sd4);
        send_points(16'sd100, 16'sd100, 16'sd99, 16'sd101);
        send_points(-16'sd5, 16'sd7, 16'sd5, -16'sd7);
    endtask

    // Random pairs: mostly wide apart, some close together for short spans.
    task automatic send_random_pair();
        t_coord fx;
        t_coord fy;
        fx = t_coord'($urandom);
        fy = t_coord'($urandom);
        if ($urandom_range(3) == 0)
            send_points(fx, fy, fx + t_coord'($urandom_range(63)) - 16'sd32,
                        fy + t_coord'($urandom_range(63)) - 16'sd32);
        else
            send_points(fx, fy, t_coord'($urandom), t_coord'($urandom));
    endtask

    task automatic test_random_pairs(int count);
        for (int n = 0; n < count; n++) begin
            quiet_stretch = (n >= count / 2) && (n < count / 2 + 100);
            send_random_pair();
        end
        quiet_stretch = 1'b0;
    endtask

    // The receiver holds off long enough for the pipeline to fill up.
    task automatic test_output_backpressure();
        wait_for_results();
        stall_hold_cycles = 200;
        for (int n = 0; n < 60; n++)
            send_random_pair();
    endtask

    // The sender stops until the pipeline has drained, then carries on.
    task automatic test_sender_pause();
        for (int n = 0; n < 20; n++)
            send_random_pair();
        wait_for_results();
        for (int n = 0; n < 20; n++)
            send_random_pair();
    endtask

    // Receiver side: a counted hold-off when asked, otherwise random stalls.
    always @(negedge i_clk) begin
        if (stall_hold_cycles > 0) begin
            i_stall = 1'b1;
            stall_hold_cycles = stall_hold_cycles - 1;
        end else begin
            i_stall = !quiet_stretch && ($urandom_range(99) < 20);
        end
    end

    // Each accepted output word is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (span_expected.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: unexpected word, span_length %0d", $realtime,
                             o_span_length);
            end else begin
                if (o_span_length !== span_expected[0]) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: span_length expected %0d, actual %0d", $realtime,
                                 span_expected[0], o_span_length);
                end
                void'(span_expected.pop_front());
            end
        end
    end

    // Watchdog: too long without a word moving on either channel ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("euclidean_distance_sqrt verification failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_coincident_points();
        test_extreme_coordinates();
        test_small_and_exact();
        test_random_pairs(400);
        test_output_backpressure();
        test_sender_pause();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && span_expected.size() == 0)
            $display("euclidean_distance_sqrt verification clean");
        else
            $display("euclidean_distance_sqrt verification failed");
        $finish;
    end

endmodule
